/* rtl/bsa_pkg.sv */
package bsa_pkg;

    localparam int unsigned WORD_BITS      = 64;
    localparam int unsigned BIT_W          = 6;
    localparam int unsigned INDEX_W        = 10;
    localparam int unsigned DEF_SLOT_COUNT = 1024;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // lowest set bit of a map word, halving search in six steps
    function automatic logic [BIT_W-1:0] lowest_set_bit(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [BIT_W-1:0]     b;
        v = w;
        b = '0;
        for (int lvl = BIT_W - 1; lvl >= 0; lvl--)
        begin
            if ((v & ((64'(1) << (1 << lvl)) - 64'(1))) == '0)
            begin
                b[lvl] = 1'b1;
                v      = v >> (1 << lvl);
            end
        end
        return b;
    endfunction

endpackage

/* rtl/bsa_req_if.sv */
interface bsa_req_if
    import bsa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [INDEX_W-1:0] slot_index;

    modport source (output valid, output kind, output slot_index, input ready);
    modport sink   (input valid, input kind, input slot_index, output ready);
endinterface

/* rtl/bsa_rsp_if.sv */
interface bsa_rsp_if
    import bsa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               success;
    logic [INDEX_W-1:0] granted_index;

    modport source (output valid, output success, output granted_index, input ready);
    modport sink   (input valid, input success, input granted_index, output ready);
endinterface

/* rtl/bsa_map_ram.sv */
module bsa_map_ram
    import bsa_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_SLOT_COUNT / WORD_BITS,
    parameter int unsigned AW    = 4
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bsa_ctrl.sv */
module bsa_ctrl
    import bsa_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT,
    parameter int unsigned AW         = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    bsa_req_if.sink              req,
    bsa_rsp_if.source            rsp,
    output logic                 ram_we,
    output logic [AW-1:0]        ram_waddr,
    output logic [WORD_BITS-1:0] ram_wdata,
    output logic                 ram_re,
    output logic [AW-1:0]        ram_raddr,
    input  logic [WORD_BITS-1:0] ram_rdata
);

    localparam int unsigned MAP_WORDS    = SLOT_COUNT / WORD_BITS;
    localparam int unsigned MAPPED_SLOTS = MAP_WORDS * WORD_BITS;
    localparam int unsigned HW           = $clog2(MAPPED_SLOTS + 1);
    localparam int unsigned HWW          = HW - BIT_W;
    localparam int unsigned CW           = (HW > INDEX_W + 1) ? HW : INDEX_W + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ALLOC = 3'd2;
    localparam logic [2:0] ST_FREE  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      word_reg, word_next;
    logic [HW-1:0]      hint_reg, hint_next;
    logic [INDEX_W-1:0] slot_reg, slot_next;
    logic               res_ok_reg, res_ok_next;
    logic [INDEX_W-1:0] res_g_reg, res_g_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg;
    logic [INDEX_W-1:0] out_g_reg;

    logic [CW-1:0]      slot_ext;
    logic [CW-1:0]      held_slot_ext;
    logic               slot_mapped;
    logic [HWW-1:0]     hint_word;
    logic               hint_in_map;
    logic [BIT_W-1:0]   first_bit;
    logic [CW-1:0]      grant_ext;
    logic               last_word;
    logic               out_load;

    assign slot_ext      = CW'(req.slot_index);
    assign held_slot_ext = CW'(slot_reg);
    assign slot_mapped   = slot_ext < CW'(MAPPED_SLOTS);
    assign hint_word     = hint_reg[HW-1:BIT_W];
    assign hint_in_map   = hint_word < HWW'(MAP_WORDS);
    assign first_bit     = lowest_set_bit(ram_rdata);
    assign grant_ext     = CW'({word_reg, first_bit});
    assign last_word     = word_reg == AW'(MAP_WORDS - 1);
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    assign req.ready         = state_reg == ST_IDLE;
    assign rsp.valid         = out_valid_reg;
    assign rsp.success       = out_ok_reg;
    assign rsp.granted_index = out_g_reg;

    // one access to the map at a time: the write-back of an item lands before the
    // next item can issue its read, so no forwarding is needed
    always_comb
    begin
        state_next  = state_reg;
        word_next   = word_reg;
        hint_next   = hint_reg;
        slot_next   = slot_reg;
        res_ok_next = res_ok_reg;
        res_g_next  = res_g_reg;
        ram_we      = 1'b0;
        ram_waddr   = word_reg;
        ram_wdata   = '1;
        ram_re      = 1'b0;
        ram_raddr   = word_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (last_word)
                begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    slot_next = req.slot_index;
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (hint_in_map)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(hint_word);
                            word_next  = AW'(hint_word);
                            state_next = ST_ALLOC;
                        end
                        else
                        begin
                            res_ok_next = 1'b0;
                            res_g_next  = '0;
                            state_next  = ST_DONE;
                        end
                    end
                    else
                    begin
                        if (slot_mapped)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(slot_ext >> BIT_W);
                            word_next  = AW'(slot_ext >> BIT_W);
                            state_next = ST_FREE;
                        end
                        else
                        begin
                            res_ok_next = 1'b0;
                            res_g_next  = '0;
                            state_next  = ST_DONE;
                        end
                    end
                end
            end
            ST_ALLOC:
            begin
                // ram_rdata holds word_reg; prefetch the next word while it is empty
                if (ram_rdata != '0)
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = ram_rdata & ~(64'(1) << first_bit);
                    hint_next   = HW'(grant_ext + CW'(1));
                    res_ok_next = 1'b1;
                    res_g_next  = grant_ext[INDEX_W-1:0];
                    state_next  = ST_DONE;
                end
                else if (last_word)
                begin
                    res_ok_next = 1'b0;
                    res_g_next  = '0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = word_reg + AW'(1);
                    word_next = word_reg + AW'(1);
                end
            end
            ST_FREE:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | (64'(1) << slot_reg[BIT_W-1:0]);
                if (CW'(hint_reg) > held_slot_ext)
                begin
                    hint_next = HW'(held_slot_ext);
                end
                res_ok_next = 1'b1;
                res_g_next  = '0;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            word_reg      <= '0;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        res_ok_reg <= res_ok_next;
        res_g_reg  <= res_g_next;
        if (out_load)
        begin
            out_ok_reg <= res_ok_reg;
            out_g_reg  <= res_g_reg;
        end
    end

endmodule

/* rtl/bitmap_slot_allocator_top.sv */
// channel  dir  modport  payload
// req      in   sink     kind, slot_index
// rsp      out  source   success, granted_index
//
// allocate: map words are read from the hint word upward until one has a free bit (up to SLOT_COUNT/64),
// one word per cycle through the single read port of the map memory
// free: read, write back, hand to the output register
// after reset the map is filled with ones word by word; req.ready stays low meanwhile
// a stalled rsp holds in the output register while the next request is taken
module bitmap_slot_allocator_top
    import bsa_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
)
(
    input  logic      clk,
    input  logic      rst_n,
    bsa_req_if.sink   req,
    bsa_rsp_if.source rsp
);

    localparam int unsigned MAP_WORDS = SLOT_COUNT / WORD_BITS;
    localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    bsa_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bsa_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

/* rtl/bsa_checker.sv */
module bsa_checker
    import bsa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_success,
    input logic [INDEX_W-1:0] rsp_granted_index
);

    // only one request is worked on at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // a failed result carries no slot number
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_success |-> rsp_granted_index == '0)
        else $error("failed result with nonzero slot");

    // map fill runs right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !req_ready)
        else $error("request taken during map fill");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_success) && $stable(rsp_granted_index))
        else $error("result changed while stalled");

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_success       (rsp.success),
    .rsp_granted_index (rsp.granted_index)
);

/* tb/bitmap_slot_allocator_top_test.sv */
`timescale 1ns / 100ps

module bitmap_slot_allocator_top_test;
    import bsa_pkg::*;

    localparam int MAP_WORDS     = DEF_SLOT_COUNT / WORD_BITS;
    localparam int LAST_SLOT     = MAP_WORDS * WORD_BITS - 1;
    localparam int HINT_W        = INDEX_W + 1;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 100;
    localparam int SEGMENT_ITEMS = 20;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic               success;
        logic [INDEX_W-1:0] granted_index;
    } grant_t;

    logic clk;
    logic rst_n;

    bsa_req_if req_ch ();
    bsa_rsp_if rsp_ch ();

    bitmap_slot_allocator_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted allocator state
    logic [WORD_BITS-1:0] free_words [MAP_WORDS];
    logic [HINT_W-1:0]    search_from;

    grant_t grants_due [$];
    int     error_count;
    bit     sender_idles;
    bit     receiver_stalls;

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // apply one request to the predicted state and return its response
    function automatic grant_t next_grant(input logic kind, input logic [INDEX_W-1:0] slot);
        grant_t g;
        bit     found;
        g     = '0;
        found = 1'b0;
        if (kind == KIND_ALLOC)
        begin
            for (int w = int'(search_from) / WORD_BITS; w < MAP_WORDS && !found; w++)
            begin
                for (int b = 0; b < WORD_BITS && !found; b++)
                begin
                    if (free_words[w][b])
                    begin
                        free_words[w][b] = 1'b0;
                        search_from      = HINT_W'(w * WORD_BITS + b + 1);
                        g.success        = 1'b1;
                        g.granted_index  = INDEX_W'(w * WORD_BITS + b);
                        found            = 1'b1;
                    end
                end
            end
        end
        else if (int'(slot) <= LAST_SLOT)
        begin
            if (search_from > HINT_W'(slot))
                search_from = HINT_W'(slot);
            free_words[slot / WORD_BITS][slot % WORD_BITS] = 1'b1;
            g.success = 1'b1;
        end
        return g;
    endfunction

    // a slot that is currently granted, if one turns up within a few tries
    function automatic logic [INDEX_W-1:0] pick_taken_slot();
        logic [INDEX_W-1:0] s;
        s = INDEX_W'($urandom);
        for (int tries = 0; tries < 32 && free_words[s / WORD_BITS][s % WORD_BITS]; tries++)
            s = INDEX_W'($urandom);
        return s;
    endfunction

    task automatic send_request(input logic kind, input logic [INDEX_W-1:0] slot);
        @(negedge clk);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.kind       = kind;
        req_ch.slot_index = slot;
        do
            @(posedge clk);
        while (!req_ch.ready);
        grants_due = {grants_due, next_grant(kind, slot)};
    endtask

    task automatic wait_for_grants();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (grants_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_basic_grant_and_release();
        send_request(KIND_ALLOC, '1);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, 10'h2AA);
        send_request(KIND_FREE, 10'd1);
        send_request(KIND_ALLOC, 10'h155);
        // release of slots above the hint that are already free, and a double release of slot 0
        send_request(KIND_FREE, INDEX_W'(LAST_SLOT));
        send_request(KIND_FREE, 10'd63);
        send_request(KIND_FREE, 10'd64);
        send_request(KIND_FREE, 10'd0);
        send_request(KIND_FREE, 10'd0);
        send_request(KIND_ALLOC, '1);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, 10'd2);
        send_request(KIND_ALLOC, 10'h3C3);
        wait_for_grants();
    endtask

    task automatic test_fill_to_exhaustion();
        int sent;
        sent = 0;
        // mostly grants with a few releases, until the hint runs off the map or 1600 are sent
        while (search_from <= HINT_W'(LAST_SLOT) && sent < 1600)
        begin
            if ($urandom_range(0, 19) == 0)
                send_request(KIND_FREE, pick_taken_slot());
            else
                send_request(KIND_ALLOC, INDEX_W'($urandom));
            sent++;
        end
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '1);
        send_request(KIND_FREE, INDEX_W'(LAST_SLOT));
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, 10'd5);
        send_request(KIND_ALLOC, '1);
        // hint sits in word 0, every word above is full
        send_request(KIND_ALLOC, '0);
        send_request(KIND_FREE, 10'd1000);
        send_request(KIND_FREE, 10'd3);
        send_request(KIND_ALLOC, '0);
        send_request(KIND_ALLOC, '0);
    endtask

    task automatic test_random_traffic();
        int alloc_pct;
        for (int seg = 0; seg < RANDOM_ITEMS / SEGMENT_ITEMS; seg++)
        begin
            case ($urandom_range(0, 2))
                0:       alloc_pct = 85;
                1:       alloc_pct = 30;
                default: alloc_pct = 55;
            endcase
            // no sender idling or receiver stalls in the last three segments
            if (seg >= RANDOM_ITEMS / SEGMENT_ITEMS - 3)
            begin
                sender_idles    = 1'b0;
                receiver_stalls = 1'b0;
            end
            else
            begin
                sender_idles    = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 4) == 0)
                wait_for_grants();
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < alloc_pct)
                    send_request(KIND_ALLOC, INDEX_W'($urandom));
                else if ($urandom_range(0, 99) < 85)
                    send_request(KIND_FREE, pick_taken_slot());
                else
                    send_request(KIND_FREE, INDEX_W'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_ALLOC;
        req_ch.slot_index = '0;
        error_count       = 0;
        sender_idles      = 1'b1;
        receiver_stalls   = 1'b1;
        foreach (free_words[i])
            free_words[i] = '1;
        search_from = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_basic_grant_and_release();
        test_fill_to_exhaustion();
        test_random_traffic();

        wait_for_grants();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && grants_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (grants_due.size() == 0)
            begin
                $error("response with no request outstanding: success %0b granted_index %0d",
                       rsp_ch.success, rsp_ch.granted_index);
                error_count++;
            end
            else
            begin
                want = grants_due.pop_front();
                if (rsp_ch.success !== want.success)
                begin
                    $error("success: expected %0b, got %0b", want.success, rsp_ch.success);
                    error_count++;
                end
                if (rsp_ch.granted_index !== want.granted_index)
                begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted_index, rsp_ch.granted_index);
                    error_count++;
                end
            end
        end
    end

    // ends the run if neither channel moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule
